// ===== src/cbos_pkg.sv =====
// Package: shared constants, types and register codes of the tile-order block sorter.
package cbos_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int COORD_BITS = 20;
	localparam int KEY_BITS   = 48;
	localparam int POS_W      = 6;
	localparam int CFG_W      = 11;
	localparam int COLS_W     = 21;
	localparam int DIV_W      = ((COORD_BITS > COLS_W) ? COORD_BITS : COLS_W) + 1;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	typedef enum logic [1:0] {
		REG_BLOCK_SIZE     = 2'd0,
		REG_CHUNK_EDGE     = 2'd1,
		REG_MATRIX_COLUMNS = 2'd2,
		REG_NONE           = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0]  block_size;
		logic [CFG_W-1:0]  chunk_edge;
		logic [COLS_W-1:0] matrix_columns;
	} cfg_t;

	typedef struct packed {
		logic                  start;
		logic [COORD_BITS-1:0] row;
		logic [COORD_BITS-1:0] col;
	} key_req_t;

	typedef struct packed {
		logic                done;
		logic [KEY_BITS-1:0] key;
	} key_rsp_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] row;
		logic [COORD_BITS-1:0] col;
		logic [KEY_BITS-1:0]   key;
	} entry_t;

	typedef enum logic [2:0] {
		KS_IDLE,
		KS_DIV_START,
		KS_DIV_WAIT,
		KS_MUL1,
		KS_MUL2,
		KS_MUL3
	} key_state_t;

	typedef enum logic [2:0] {
		S_LOAD,
		S_KEY,
		S_SCAN,
		S_EMIT
	} top_state_t;

endpackage

// ===== src/cbos_divider.sv =====
// Restoring divider: one quotient bit per cycle, unsigned.
module cbos_divider import cbos_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [CFG_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient,
	output logic [CFG_W-1:0] remainder
);

	localparam int CNT_DW = $clog2(DIV_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_DW-1:0] cnt_q;
	logic [DIV_W-1:0]  quo_q;
	logic [CFG_W-1:0]  rem_q;
	logic [CFG_W-1:0]  den_q;
	logic [CFG_W:0]    shifted;
	logic [CFG_W:0]    diff;
	logic              ge;

	always_comb begin
		shifted = {rem_q, quo_q[DIV_W-1]};
		diff    = shifted - {1'b0, den_q};
		ge      = shifted >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_DW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_DW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_DW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== src/cbos_key_unit.sv =====
// Tile-order key sequencer: six divisions on a shared divider, then three multiply steps.
module cbos_key_unit import cbos_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  key_req_t req,
	output key_rsp_t rsp
);

	key_state_t state_q, state_d;

	logic [2:0]                  step_q;
	logic [COORD_BITS-1:0]       row_q, col_q;
	logic [COORD_BITS-1:0]       bi_q, bj_q, bq_q, cq_q;
	logic [CFG_W-1:0]            br_q, cr_q;
	logic [COLS_W-1:0]           t_q;
	logic [DIV_W-1:0]            cc_q;
	logic [KEY_BITS-1:0]         acc_q;
	logic                        done_q;

	logic [CFG_W-1:0]            bs_eff, c_eff;
	logic                        div_start, div_done;
	logic [DIV_W-1:0]            div_num, div_quo;
	logic [CFG_W-1:0]            div_den, div_rem;
	logic [COORD_BITS+DIV_W-1:0] prod1;
	logic [KEY_BITS-1:0]         mul_a;
	logic [KEY_BITS+CFG_W-1:0]   prod_c;

	assign bs_eff = (cfg.block_size == '0) ? CFG_W'(1) : cfg.block_size;
	assign c_eff  = (cfg.chunk_edge == '0) ? CFG_W'(1) : cfg.chunk_edge;

	always_comb begin
		div_num = '0;
		div_den = bs_eff;
		case (step_q)
			3'd0: div_num = DIV_W'(row_q);
			3'd1: div_num = DIV_W'(col_q);
			3'd2: div_num = DIV_W'(cfg.matrix_columns);
			3'd3: begin
				div_num = DIV_W'(t_q) + DIV_W'(c_eff) - DIV_W'(1);
				div_den = c_eff;
			end
			3'd4: begin
				div_num = DIV_W'(bi_q);
				div_den = c_eff;
			end
			3'd5: begin
				div_num = DIV_W'(bj_q);
				div_den = c_eff;
			end
			default: div_num = '0;
		endcase
	end

	cbos_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_num),
		.divisor   (div_den),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign prod1 = bq_q * cc_q;
	assign mul_a = (state_q == KS_MUL2) ? acc_q + KEY_BITS'(cq_q) : acc_q + KEY_BITS'(br_q);
	assign prod_c = mul_a * c_eff;

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			KS_IDLE:      if (req.start) state_d = KS_DIV_START;
			KS_DIV_START: begin
				div_start = 1'b1;
				state_d   = KS_DIV_WAIT;
			end
			KS_DIV_WAIT:  if (div_done) state_d = (step_q == 3'd5) ? KS_MUL1 : KS_DIV_START;
			KS_MUL1:      state_d = KS_MUL2;
			KS_MUL2:      state_d = KS_MUL3;
			KS_MUL3:      state_d = KS_IDLE;
			default:      state_d = KS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KS_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == KS_MUL3);
			if (state_q == KS_IDLE && req.start) step_q <= '0;
			else if (state_q == KS_DIV_WAIT && div_done) step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == KS_IDLE && req.start) begin
			row_q <= req.row;
			col_q <= req.col;
		end
		if (state_q == KS_DIV_WAIT && div_done) begin
			case (step_q)
				3'd0: bi_q <= div_quo[COORD_BITS-1:0];
				3'd1: bj_q <= div_quo[COORD_BITS-1:0];
				3'd2: t_q  <= div_quo[COLS_W-1:0];
				3'd3: cc_q <= div_quo;
				3'd4: begin
					bq_q <= div_quo[COORD_BITS-1:0];
					br_q <= div_rem;
				end
				3'd5: begin
					cq_q <= div_quo[COORD_BITS-1:0];
					cr_q <= div_rem;
				end
				default: t_q <= t_q;
			endcase
		end
		case (state_q)
			KS_MUL1: acc_q <= KEY_BITS'(prod1);
			KS_MUL2: acc_q <= prod_c[KEY_BITS-1:0];
			KS_MUL3: acc_q <= prod_c[KEY_BITS-1:0] + KEY_BITS'(cr_q);
			default: acc_q <= acc_q;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.key  = acc_q;

endmodule

// ===== src/chunked_block_order_sorter.sv =====
// Top level: config registers, entry memory, load control and scan-select sort output.
// Load: each stored item waits in S_KEY, with in_stall high, while the key unit runs
//   its divisions on the shared bit-serial divider; a dropped item is not stored.
// Sort: each result needs one pass over the entry memory read port, so a set of n
//   entries drains in n passes; output has one register stage.
// Reset clears control state, counters and config (all registers to 1); the memory is
//   not cleared, since only written entries are read.
module chunked_block_order_sorter import cbos_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] row_index,
	input  logic [COORD_BITS-1:0] column_index,
	input  logic                  last_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_BITS-1:0] sorted_row,
	output logic [COORD_BITS-1:0] sorted_column,
	output logic [POS_W-1:0]      source_position,
	output logic                  overflow,
	output logic                  end_of_run
);

	top_state_t state_q, state_d;

	cfg_t                  cfg_q;
	reg_idx_t              reg_sel;
	logic                  cfg_we;

	logic [CNT_W-1:0]      count_q;
	logic                  dropped_q;
	logic [COORD_BITS-1:0] row_q, col_q;
	logic                  last_q;

	key_req_t              key_req;
	key_rsp_t              key_rsp;

	entry_t                mem [MAX_BLOCKS];
	entry_t                rd_data_s1;
	logic                  rd_valid_s1;
	logic [IDX_W-1:0]      rd_pos_s1;
	logic [CNT_W-1:0]      scan_idx_q;
	logic [CNT_W-1:0]      emit_cnt_q;

	logic                  have_prev_q;
	logic [KEY_BITS-1:0]   prev_key_q;
	logic [IDX_W-1:0]      prev_pos_q;
	logic                  best_valid_q;
	entry_t                best_q;
	logic [IDX_W-1:0]      best_pos_q;

	logic                  accept, full, mem_we, rd_en, scan_init, emit_fire, emit_last;
	logic                  above, better;
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] out_row_q, out_col_q;
	logic [POS_W-1:0]      out_pos_q;
	logic                  out_ovf_q, out_end_q;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_we  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_sel)
			REG_BLOCK_SIZE:     prdata = DATA_W'(cfg_q.block_size);
			REG_CHUNK_EDGE:     prdata = DATA_W'(cfg_q.chunk_edge);
			REG_MATRIX_COLUMNS: prdata = DATA_W'(cfg_q.matrix_columns);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_size     <= CFG_W'(1);
			cfg_q.chunk_edge     <= CFG_W'(1);
			cfg_q.matrix_columns <= COLS_W'(1);
		end else if (cfg_we) begin
			case (reg_sel)
				REG_BLOCK_SIZE:     cfg_q.block_size     <= pwdata[CFG_W-1:0];
				REG_CHUNK_EDGE:     cfg_q.chunk_edge     <= pwdata[CFG_W-1:0];
				REG_MATRIX_COLUMNS: cfg_q.matrix_columns <= pwdata[COLS_W-1:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	// key unit
	assign in_stall      = (state_q != S_LOAD);
	assign accept        = in_valid && !in_stall;
	assign full          = (count_q == CNT_W'(MAX_BLOCKS));
	assign key_req.start = accept && !full;
	assign key_req.row   = row_index;
	assign key_req.col   = column_index;

	cbos_key_unit u_key (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (key_req),
		.rsp    (key_rsp)
	);

	// ordering is on {key, position}, which keeps equal keys in load order
	assign above  = !have_prev_q || ({rd_data_s1.key, rd_pos_s1} > {prev_key_q, prev_pos_q});
	assign better = !best_valid_q || ({rd_data_s1.key, rd_pos_s1} < {best_q.key, best_pos_q});
	assign emit_last = (emit_cnt_q + 1'b1) == count_q;

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		rd_en     = 1'b0;
		scan_init = 1'b0;
		emit_fire = 1'b0;
		case (state_q)
			S_LOAD: begin
				if (accept) begin
					if (!full) begin
						state_d = S_KEY;
					end else if (last_item) begin
						state_d   = S_SCAN;
						scan_init = 1'b1;
					end
				end
			end
			S_KEY: begin
				if (key_rsp.done) begin
					mem_we = 1'b1;
					if (last_q) begin
						state_d   = S_SCAN;
						scan_init = 1'b1;
					end else begin
						state_d = S_LOAD;
					end
				end
			end
			S_SCAN: begin
				if (scan_idx_q < count_q) rd_en = 1'b1;
				else if (!rd_valid_s1) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit_fire = 1'b1;
					state_d   = emit_last ? S_LOAD : S_SCAN;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			count_q      <= '0;
			dropped_q    <= 1'b0;
			rd_valid_s1  <= 1'b0;
			scan_idx_q   <= '0;
			emit_cnt_q   <= '0;
			have_prev_q  <= 1'b0;
			best_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_en;
			if (accept && full) dropped_q <= 1'b1;
			if (mem_we) count_q <= count_q + 1'b1;
			if (rd_en) scan_idx_q <= scan_idx_q + 1'b1;
			if (rd_valid_s1 && above && better) best_valid_q <= 1'b1;
			if (scan_init) begin
				scan_idx_q   <= '0;
				emit_cnt_q   <= '0;
				have_prev_q  <= 1'b0;
				best_valid_q <= 1'b0;
			end
			if (emit_fire) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (emit_fire) begin
				have_prev_q  <= !emit_last;
				best_valid_q <= 1'b0;
				scan_idx_q   <= '0;
				emit_cnt_q   <= emit_cnt_q + 1'b1;
				if (emit_last) begin
					count_q     <= '0;
					dropped_q   <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q  <= row_index;
			col_q  <= column_index;
			last_q <= last_item;
		end
		if (mem_we) mem[count_q[IDX_W-1:0]] <= '{row: row_q, col: col_q, key: key_rsp.key};
		if (rd_en) begin
			rd_data_s1 <= mem[scan_idx_q[IDX_W-1:0]];
			rd_pos_s1  <= scan_idx_q[IDX_W-1:0];
		end
		if (rd_valid_s1 && above && better) begin
			best_q     <= rd_data_s1;
			best_pos_q <= rd_pos_s1;
		end
		if (emit_fire) begin
			prev_key_q <= best_q.key;
			prev_pos_q <= best_pos_q;
			out_row_q  <= best_q.row;
			out_col_q  <= best_q.col;
			out_pos_q  <= POS_W'(best_pos_q);
			out_ovf_q  <= dropped_q;
			out_end_q  <= emit_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign sorted_row      = out_row_q;
	assign sorted_column   = out_col_q;
	assign source_position = out_pos_q;
	assign overflow        = out_ovf_q;
	assign end_of_run      = out_end_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BLOCKS))
		else $error("entry count beyond capacity");

	a_emit_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> best_valid_q)
		else $error("emit without a selected entry");

	a_key_done_in_key: assert property (@(posedge clk) disable iff (!arst_n)
		key_rsp.done |-> (state_q == S_KEY))
		else $error("key result outside key wait");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (count_q != '0))
		else $error("sort started on empty set");

endmodule

// ===== tb/sv/chunked_block_order_sorter_test.sv =====
// Testbench for the tile-order block sorter: random and directed block sets checked against a local predictor.
module chunked_block_order_sorter_test import cbos_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 900000;
	localparam int DRAIN_WAIT  = 300;
	localparam logic [COORD_BITS-1:0] CMAX = '1;

	typedef struct {
		logic [COORD_BITS-1:0] row;
		logic [COORD_BITS-1:0] col;
		logic                  last;
	} block_item_t;

	typedef struct {
		logic [COORD_BITS-1:0] row;
		logic [COORD_BITS-1:0] col;
		logic [POS_W-1:0]      pos;
		logic                  ovf;
		logic                  eor;
	} sorted_entry_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic [COORD_BITS-1:0] row_index = '0, column_index = '0;
	logic last_item = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [COORD_BITS-1:0] sorted_row, sorted_column;
	logic [POS_W-1:0] source_position;
	logic overflow, end_of_run;

	chunked_block_order_sorter DUT (.*);

	block_item_t   pending_q[$];
	sorted_entry_t sorted_q[$];
	int unsigned   cycle_cnt = 0;
	int unsigned   err_cnt = 0;

	// shadow of the config registers and the entry store
	logic [CFG_W-1:0]      cfg_bs = 1, cfg_c = 1;
	logic [COLS_W-1:0]     cfg_cols = 1;
	logic [COORD_BITS-1:0] st_row[MAX_BLOCKS];
	logic [COORD_BITS-1:0] st_col[MAX_BLOCKS];
	logic [KEY_BITS-1:0]   st_key[MAX_BLOCKS];
	int                    st_cnt = 0;
	logic                  st_drop = 0;

	initial forever #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[chunked_block_order_sorter] ERROR");
			$finish;
		end
	end

	// no random idling inside this window
	function automatic bit idle_now();
		return !(cycle_cnt >= 30000 && cycle_cnt < 70000) && ($urandom_range(99) < 11);
	endfunction

	function automatic logic [KEY_BITS-1:0] tile_key(logic [COORD_BITS-1:0] r,
			logic [COORD_BITS-1:0] cl);
		longint unsigned bs, c, bi, bj, chunks, k;
		bs = (cfg_bs == 0) ? 1 : cfg_bs;
		c = (cfg_c == 0) ? 1 : cfg_c;
		bi = r / bs;
		bj = cl / bs;
		chunks = (cfg_cols / bs + c - 1) / c;
		k = (bi / c) * chunks + bj / c;
		k = (k * c + bi % c) * c + bj % c;
		return k[KEY_BITS-1:0];
	endfunction

	task automatic send_block(logic [COORD_BITS-1:0] r, logic [COORD_BITS-1:0] cl, logic lst);
		block_item_t it;
		sorted_entry_t e;
		bit used[MAX_BLOCKS];
		int best;
		it.row = r; it.col = cl; it.last = lst;
		pending_q.push_back(it);
		if (st_cnt < MAX_BLOCKS) begin
			st_row[st_cnt] = r;
			st_col[st_cnt] = cl;
			st_key[st_cnt] = tile_key(r, cl);
			st_cnt++;
		end else
			st_drop = 1;
		if (!lst)
			return;
		foreach (used[i]) used[i] = 0;
		// stable selection: strict compare keeps the earliest load position on ties
		for (int k = 0; k < st_cnt; k++) begin
			best = -1;
			for (int j = 0; j < st_cnt; j++)
				if (!used[j] && (best < 0 || st_key[j] < st_key[best]))
					best = j;
			used[best] = 1;
			e.row = st_row[best];
			e.col = st_col[best];
			e.pos = best[POS_W-1:0];
			e.ovf = st_drop;
			e.eor = (k == st_cnt - 1);
			sorted_q.push_back(e);
		end
		st_cnt = 0;
		st_drop = 0;
	endtask

	task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDR_W'(4 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic set_config(int bs, int c, int cols);
		cfg_bs = CFG_W'(bs); cfg_c = CFG_W'(c); cfg_cols = COLS_W'(cols);
		reg_write(REG_BLOCK_SIZE, bs);
		reg_write(REG_CHUNK_EDGE, c);
		reg_write(REG_MATRIX_COLUMNS, cols);
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || sorted_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic [COORD_BITS-1:0] rand_coord(int span);
		case ($urandom_range(5))
			0: return COORD_BITS'($urandom);
			1: return CMAX;
			2: return 0;
			default: return COORD_BITS'($urandom_range(span));
		endcase
	endfunction

	task automatic random_set(int n, int span);
		logic [COORD_BITS-1:0] r, cl;
		r = 0; cl = 0;
		for (int k = 0; k < n; k++) begin
			// repeat the previous coordinate now and then for equal keys
			if (k == 0 || $urandom_range(6) != 0) begin
				r = rand_coord(span);
				cl = rand_coord(span);
			end
			send_block(r, cl, k == n - 1);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// directed: reset config, extremes, single-entry set, ties
		send_block(CMAX, CMAX, 0);
		send_block(0, 0, 0);
		send_block(CMAX, 0, 0);
		send_block(0, CMAX, 0);
		send_block(5, 5, 0);
		send_block(5, 5, 1);
		send_block(7, 3, 1);
		drain();
		set_config(16, 4, 1000);
		send_block(100, 900, 0);
		send_block(15, 15, 0);
		send_block(64, 0, 0);
		send_block(0, 64, 0);
		send_block(CMAX, CMAX, 1);
		drain();
		set_config(0, 0, 0);
		send_block(3, 9, 0);
		send_block(9, 3, 0);
		send_block(0, 0, 1);
		drain();
		set_config(1024, 1024, 1 << 20);
		send_block(CMAX, 1023, 0);
		send_block(1024, CMAX, 0);
		send_block(0, 0, 1);
		drain();

		// random phases
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_config(1, 1, 1 << 20);
				1: set_config($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 4096));
				2: set_config($urandom_range(2047), $urandom_range(2047), $urandom_range(2097151));
				3: set_config(2047, 2047, 2097151);
				4: set_config($urandom_range(1, 64), $urandom_range(1, 32), $urandom);
				default: set_config($urandom_range(1, 4), $urandom_range(1, 1024), 1 << 20);
			endcase
			if (ph == 1 || ph == 4)
				random_set(MAX_BLOCKS + $urandom_range(1, 3), 4095);  // overflow set
			for (int s = 0; s < 3; s++)
				random_set($urandom_range(1, 8), (ph % 2) ? 4095 : 1048575);
			drain();
		end

		if (err_cnt == 0)
			$display("[chunked_block_order_sorter] OK");
		else
			$display("[chunked_block_order_sorter] ERROR");
		$finish;
	end

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!(in_valid && in_stall)) begin
			// the item at the head stays queued until it is accepted
			if (in_valid)
				void'(pending_q.pop_front());
			if (pending_q.size() > 0 && !idle_now()) begin
				block_item_t it;
				it = pending_q[0];
				row_index <= it.row;
				column_index <= it.col;
				last_item <= it.last;
				in_valid <= 1;
			end else
				in_valid <= 0;
		end
	end

	// output monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			out_stall <= idle_now();
			if (out_valid && !out_stall) begin
				if (sorted_q.size() == 0) begin
					err_cnt <= err_cnt + 1;
					if (err_cnt < 10)
						$display("unexpected result row=%h col=%h pos=%0d",
							sorted_row, sorted_column, source_position);
				end else begin
					sorted_entry_t e;
					e = sorted_q.pop_front();
					if (sorted_row !== e.row || sorted_column !== e.col ||
							source_position !== e.pos || overflow !== e.ovf ||
							end_of_run !== e.eor) begin
						err_cnt <= err_cnt + 1;
						if (err_cnt < 10)
							$display("mismatch exp row=%h col=%h pos=%0d ovf=%b eor=%b got row=%h col=%h pos=%0d ovf=%b eor=%b",
								e.row, e.col, e.pos, e.ovf, e.eor, sorted_row, sorted_column,
								source_position, overflow, end_of_run);
					end
				end
			end
		end
	end

endmodule

// ===== chunked_block_order_sorter.f =====
src/cbos_pkg.sv
src/cbos_divider.sv
src/cbos_key_unit.sv
src/chunked_block_order_sorter.sv
tb/sv/chunked_block_order_sorter_test.sv
